/* src/fpx_pkg.sv */
// ----------------------------------------------------------------------------
// fpx_pkg
// Shared types and codes for the priority-extract queue: entry layout,
// action codes and status codes.
// ----------------------------------------------------------------------------
package fpx_pkg;

   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 8;
   localparam int OCC_W    = 5;

   typedef logic [1:0] action_type;
   localparam action_type ACT_APPEND = 2'd0;
   localparam action_type ACT_POP    = 2'd1;
   localparam action_type ACT_BEST   = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

endpackage

/* src/fpx_slot_ram.sv */
// ----------------------------------------------------------------------------
// fpx_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpx_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  fpx_pkg::entry_type    wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output fpx_pkg::entry_type    rd_data
);

   fpx_pkg::entry_type mem [DEPTH];
   fpx_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fifo_with_priority_extract_unit.sv */
// ----------------------------------------------------------------------------
// fifo_with_priority_extract_unit
// Arrival-order queue of (handle, priority) entries with pop-oldest and
// remove-lowest-priority actions.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Entries sit oldest first in a slot memory
// with one read and one write port, and the scan and copy pass walk that
// memory one slot per cycle. Append, a removal on an empty queue and an unused
// action go straight to the result state. Pop reads only the oldest entry;
// remove-best runs a scan that reads every entry to find the lowest priority
// (oldest wins a tie). Both then run a copy pass that moves each younger
// entry down one slot to close the gap. A stalled earlier result in the output
// register holds the unit in the result state. One beat is worked on at a
// time; a new beat is taken while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module fifo_with_priority_extract_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [fpx_pkg::HANDLE_W-1:0]   req_entry_handle,
   input  logic [fpx_pkg::PRIO_W-1:0]     req_entry_priority,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fpx_pkg::HANDLE_W-1:0]   rsp_removed_handle,
   output logic [fpx_pkg::PRIO_W-1:0]     rsp_removed_priority,
   output logic [1:0]                     rsp_status,
   output logic [fpx_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_SETUP  = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        dat_ptr_ff, dat_ptr_in;
   logic [CW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]        scan_end_ff, scan_end_in;
   logic [CW-1:0]        best_off_ff, best_off_in;
   fpx_pkg::entry_type   best_ff, best_in;
   fpx_pkg::status_type  status_ff, status_in;
   logic                 dec_ff, dec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [fpx_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [fpx_pkg::PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   fpx_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [fpx_pkg::OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                 accept;
   logic [CW-1:0]        next_off;
   logic [CW-1:0]        count_left;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [AW-1:0]        mem_raddr;
   fpx_pkg::entry_type   mem_wdata;
   fpx_pkg::entry_type   mem_rdata;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign next_off  = best_off_ff + ONE_C;
   assign count_left = count_ff - CW'(dec_ff);

   fpx_slot_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (AW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      dat_ptr_in    = dat_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      scan_end_in   = scan_end_ff;
      best_off_in   = best_off_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      dec_in        = dec_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_handle_in = rsp_handle_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[AW-1:0];
      mem_wdata.handle = req_entry_handle;
      mem_wdata.prio   = req_entry_priority;
      mem_raddr     = rd_ptr_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dec_in    = 1'b0;
               best_in   = '0;
               status_in = fpx_pkg::ST_OK;
               state_in  = S_RESULT;
               case (req_action)
                  fpx_pkg::ACT_APPEND: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = fpx_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + ONE_C;
                     end
                  end
                  fpx_pkg::ACT_POP, fpx_pkg::ACT_BEST: begin
                     if (count_ff == '0) begin
                        status_in = fpx_pkg::ST_EMPTY;
                     end else begin
                        mem_raddr   = '0;
                        rd_ptr_in   = ONE_C;
                        dat_ptr_in  = '0;
                        scan_end_in = (req_action == fpx_pkg::ACT_POP) ? ONE_C : count_ff;
                        dec_in      = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // oldest wins a tie: strict compare
            if (dat_ptr_ff == '0 || mem_rdata.prio < best_ff.prio) begin
               best_in     = mem_rdata;
               best_off_in = dat_ptr_ff;
            end
            if (rd_ptr_ff < scan_end_ff) begin
               rd_ptr_in = rd_ptr_ff + ONE_C;
            end
            dat_ptr_in = dat_ptr_ff + ONE_C;
            if (dat_ptr_ff + ONE_C == scan_end_ff) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            wr_ptr_in = best_off_ff;
            rd_ptr_in = best_off_ff + TWO_C;
            mem_raddr = next_off[AW-1:0];
            if (next_off >= count_ff) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            wr_ptr_in = wr_ptr_ff + ONE_C;
            if (rd_ptr_ff == count_ff) begin
               state_in = S_RESULT;
            end else begin
               rd_ptr_in = rd_ptr_ff + ONE_C;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = best_ff.handle;
               rsp_prio_in   = best_ff.prio;
               rsp_status_in = status_ff;
               rsp_occ_in    = fpx_pkg::OCC_W'(count_left);
               count_in      = count_left;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      dat_ptr_ff    <= dat_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      scan_end_ff   <= scan_end_in;
      best_off_ff   <= best_off_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
      dec_ff        <= dec_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_removed_handle   = rsp_handle_ff;
   assign rsp_removed_priority = rsp_prio_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_occupancy        = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above queue depth");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> (wr_ptr_ff + ONE_C < count_ff))
      else $error("gap close writes outside held entries");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && status_ff == fpx_pkg::ST_FULL) |-> count_ff == DEPTH_C)
      else $error("full reported on a queue that is not full");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted beat not worked on");

endmodule

/* verif/fpx_queue_checker.sv */
// ----------------------------------------------------------------------------
// fpx_queue_checker
// Watches both channels of the priority-extract queue, keeps its own copy of
// the held entries, works out the result of every accepted request beat and
// compares each accepted response beat, field by field, with the oldest one
// still due.
// ----------------------------------------------------------------------------
module fpx_queue_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [fpx_pkg::HANDLE_W-1:0]   req_entry_handle,
   input  logic [fpx_pkg::PRIO_W-1:0]     req_entry_priority,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [fpx_pkg::HANDLE_W-1:0]   rsp_removed_handle,
   input  logic [fpx_pkg::PRIO_W-1:0]     rsp_removed_priority,
   input  logic [1:0]                     rsp_status,
   input  logic [fpx_pkg::OCC_W-1:0]      rsp_occupancy,
   output int                             mismatch_count,
   output int                             results_due,
   output int                             results_checked,
   output int                             full_seen,
   output int                             empty_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [fpx_pkg::HANDLE_W-1:0] handle;
      logic [fpx_pkg::PRIO_W-1:0]   prio;
      fpx_pkg::status_type          status;
      logic [fpx_pkg::OCC_W-1:0]    occ;
   } outcome_type;

   fpx_pkg::entry_type held[$];
   outcome_type        due_results[$];
   outcome_type        want;
   outcome_type        got;

   function automatic outcome_type apply_action(
      input fpx_pkg::action_type           act,
      input logic [fpx_pkg::HANDLE_W-1:0]  handle,
      input logic [fpx_pkg::PRIO_W-1:0]    prio);
      outcome_type        res;
      fpx_pkg::entry_type fresh;
      int                 pick;
      res = '0;
      res.status = fpx_pkg::ST_OK;
      pick = 0;
      case (act)
         fpx_pkg::ACT_APPEND: begin
            if (held.size() >= QUEUE_DEPTH) begin
               res.status = fpx_pkg::ST_FULL;
            end else begin
               fresh.handle = handle;
               fresh.prio = prio;
               held.push_back(fresh);
            end
         end
         fpx_pkg::ACT_POP, fpx_pkg::ACT_BEST: begin
            if (held.size() == 0) begin
               res.status = fpx_pkg::ST_EMPTY;
            end else begin
               if (act == fpx_pkg::ACT_BEST) begin
                  for (int i = 1; i < held.size(); i++) begin
                     if (held[i].prio < held[pick].prio) pick = i;
                  end
               end
               res.handle = held[pick].handle;
               res.prio = held[pick].prio;
               held.delete(pick);
            end
         end
         default: ;
      endcase
      res.occ = fpx_pkg::OCC_W'(held.size());
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held.delete();
         due_results.delete();
         mismatch_count = 0;
         results_checked = 0;
         full_seen = 0;
         empty_seen = 0;
      end else begin
         if (req_valid && !req_stall) begin
            due_results.push_back(apply_action(req_action, req_entry_handle,
                                               req_entry_priority));
         end
         if (rsp_valid && !rsp_stall) begin
            got.handle = rsp_removed_handle;
            got.prio = rsp_removed_priority;
            got.status = rsp_status;
            got.occ = rsp_occupancy;
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with none due: handle %h prio %h %s",
                           $realtime, got.handle, got.prio,
                           $sformatf("status %0d occ %0d", got.status, got.occ));
            end else begin
               want = due_results.pop_front();
               results_checked++;
               if (want.status == fpx_pkg::ST_FULL) full_seen++;
               if (want.status == fpx_pkg::ST_EMPTY) empty_seen++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: beat %0d exp handle %h prio %h status %0d occ %0d",
                              $realtime, results_checked, want.handle, want.prio,
                              want.status, want.occ);
                     $display("%0t: beat %0d got handle %h prio %h status %0d occ %0d",
                              $realtime, results_checked, got.handle, got.prio,
                              got.status, got.occ);
                  end
               end
            end
         end
      end
      results_due <= due_results.size();
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the priority-extract queue with a directed opening (empty and full
// queue, unused action, priority ties, popping the last entry) and then
// phases of random actions biased toward filling or draining, with bursty
// requests and a varying response stall. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_BEATS = 1100;
   localparam int DRAIN_CYCLES = 40;
   localparam fpx_pkg::action_type ACT_UNUSED = 2'd3;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [1:0]                   req_action;
   logic [fpx_pkg::HANDLE_W-1:0] req_entry_handle;
   logic [fpx_pkg::PRIO_W-1:0]   req_entry_priority;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [fpx_pkg::HANDLE_W-1:0] rsp_removed_handle;
   logic [fpx_pkg::PRIO_W-1:0]   rsp_removed_priority;
   logic [1:0]                   rsp_status;
   logic [fpx_pkg::OCC_W-1:0]    rsp_occupancy;

   int  mismatch_count;
   int  results_due;
   int  results_checked;
   int  full_seen;
   int  empty_seen;
   int  burst_left;
   int  sent_count[4];
   bit  stim_done;

   fifo_with_priority_extract_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_entry_handle     (req_entry_handle),
      .req_entry_priority   (req_entry_priority),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_removed_handle   (rsp_removed_handle),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_status           (rsp_status),
      .rsp_occupancy        (rsp_occupancy)
   );

   fpx_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_entry_handle     (req_entry_handle),
      .req_entry_priority   (req_entry_priority),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_removed_handle   (rsp_removed_handle),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_status           (rsp_status),
      .rsp_occupancy        (rsp_occupancy),
      .mismatch_count       (mismatch_count),
      .results_due          (results_due),
      .results_checked      (results_checked),
      .full_seen            (full_seen),
      .empty_seen           (empty_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: stall pattern switches at random among four modes.
   initial begin
      int mode;
      int mode_left;
      rsp_stall = 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (stim_done) begin
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ($urandom_range(0, 19) != 0);
            endcase
         end
      end
   end

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // One request beat; valid stays high into the next beat within a burst.
   task automatic send_beat(input fpx_pkg::action_type act,
                            input logic [fpx_pkg::HANDLE_W-1:0] handle,
                            input logic [fpx_pkg::PRIO_W-1:0] prio);
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_entry_handle <= handle;
      req_entry_priority <= prio;
      do @(posedge clock); while (req_stall);
      sent_count[act]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 10);
         idle_cycles($urandom_range(1, 8));
      end
   endtask

   function automatic logic [fpx_pkg::PRIO_W-1:0] random_prio();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return fpx_pkg::PRIO_W'($urandom_range(0, 7));
         default: return fpx_pkg::PRIO_W'($urandom);
      endcase
   endfunction

   initial begin
      int                           phase_len;
      int                           fill_pct;
      int                           roll;
      int                           random_sent;
      fpx_pkg::action_type          act;
      logic [fpx_pkg::PRIO_W-1:0]   fill_prio;
      logic [fpx_pkg::HANDLE_W-1:0] fill_handle;

      reset = 1'b1;
      req_valid = 1'b0;
      req_action = fpx_pkg::ACT_APPEND;
      req_entry_handle = '0;
      req_entry_priority = '0;
      stim_done = 1'b0;
      burst_left = 0;
      foreach (sent_count[i]) sent_count[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening
      send_beat(fpx_pkg::ACT_POP, 16'hFFFF, 8'hFF);
      send_beat(fpx_pkg::ACT_BEST, 16'hA5A5, 8'h5A);
      send_beat(ACT_UNUSED, 16'h1234, 8'h56);
      send_beat(fpx_pkg::ACT_APPEND, 16'hFFFF, 8'hFF);
      send_beat(fpx_pkg::ACT_POP, 16'h0000, 8'h00);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         // two entries tie on the lowest priority
         if (i == 3 || i == 7) fill_prio = 8'h01;
         else if (i == 0) fill_prio = 8'hFF;
         else fill_prio = fpx_pkg::PRIO_W'(8'h80 + i);
         if (i == 0) fill_handle = 16'h0000;
         else if (i == 1) fill_handle = 16'hFFFF;
         else fill_handle = fpx_pkg::HANDLE_W'(16'h1000 * i + i);
         send_beat(fpx_pkg::ACT_APPEND, fill_handle, fill_prio);
      end
      send_beat(fpx_pkg::ACT_APPEND, 16'hDEAD, 8'h00);
      send_beat(fpx_pkg::ACT_BEST, 16'h0000, 8'h00);
      send_beat(fpx_pkg::ACT_BEST, 16'h0000, 8'h00);
      send_beat(fpx_pkg::ACT_POP, 16'h0000, 8'h00);

      // random phases, each leaning toward filling, draining or neither
      random_sent = 0;
      while (random_sent < RANDOM_BEATS) begin
         phase_len = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0: fill_pct = 15;
            1: fill_pct = 50;
            default: fill_pct = 85;
         endcase
         repeat (phase_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) act = ACT_UNUSED;
            else if (roll < 3 + fill_pct) act = fpx_pkg::ACT_APPEND;
            else act = $urandom_range(0, 1) ? fpx_pkg::ACT_POP : fpx_pkg::ACT_BEST;
            send_beat(act, fpx_pkg::HANDLE_W'($urandom), random_prio());
            if (act != ACT_UNUSED) random_sent++;
         end
      end

      idle_cycles(1);
      stim_done = 1'b1;
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d appends, %0d pops, %0d remove-best, %0d unused actions.",
               sent_count[fpx_pkg::ACT_APPEND], sent_count[fpx_pkg::ACT_POP],
               sent_count[fpx_pkg::ACT_BEST], sent_count[ACT_UNUSED]);
      $display("Checked %0d responses, %0d on a full queue, %0d on an empty one.",
               results_checked, full_seen, empty_seen);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/fpx_pkg.sv
src/fpx_slot_ram.sv
src/fifo_with_priority_extract_unit.sv
verif/fpx_queue_checker.sv
verif/tb_top.sv
